### design/sqvb_pkg.sv
// Package: shared types, codes and the sine helper for the quad vertex batcher.
`timescale 1ns / 1ps
package sqvb_pkg;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TEX_FULL   = 2'd1;
  localparam logic [1:0] ST_BATCH_FULL = 2'd2;

  localparam logic [31:0] WHITE_RGBA  = 32'hFFFF_FFFF;
  localparam logic [15:0] UNIT_TILING = 16'd256;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        angle_turn;
    logic               textured;
    logic [15:0]        texture_id;
    logic [15:0]        tiling;
    logic [31:0]        color_rgba;
  } quad_req_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        vert_rgba;
    logic               tex_u;
    logic               tex_v;
    logic [4:0]         tex_slot;
    logic [15:0]        tiling_out;
    logic [16:0]        index_count;
    logic [1:0]         status;
    logic               last;
  } vert_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG,
    S_MUL,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MISS,
    S_VERT,
    S_ONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic clear;
    logic trig;
    logic mul;
    logic scan_next;
    logic hit;
    logic miss;
    logic load_vert;
    logic load_one;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       batch_full;
    logic       textured;
    logic       scan_end;
    logic       hit;
    logic       out_free;
    logic       last_vert;
  } dp_sts_t;

  // Q16 sine of a 2^-32 turn phase; quadrant fold, Taylor series to x^11.
  // Evaluated on constants only, to build the lookup tables.
  function automatic logic signed [17:0] sine_of_phase(input logic [31:0] p);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    longint          v;
    r = {34'd0, p[29:0]};
    if (p[30]) begin
      r = 64'h4000_0000 - r;
    end
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = x;
    sum = longint'(x);
    t = ((t * x2) >> 30) / 6;
    sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 20;
    sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 42;
    sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 72;
    sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 110;
    sum = sum - longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 8192) >>> 14;
    if (v > 65536) begin
      v = 65536;
    end
    if (p[31]) begin
      v = -v;
    end
    return 18'(v);
  endfunction

endpackage

### design/sqvb_intf.sv
// Interfaces: quad command channel and vertex result channel.
`timescale 1ns / 1ps
interface sqvb_cmd_if;
  logic                valid;
  logic                ready;
  sqvb_pkg::quad_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sqvb_vert_if;
  logic                valid;
  logic                ready;
  sqvb_pkg::vert_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/sqvb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sqvb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/sqvb_ctrl.sv
// Controller state machine for the quad vertex batcher.
`timescale 1ns / 1ps
module sqvb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sqvb_pkg::dp_sts_t sts_i,
  output sqvb_pkg::dp_cmd_t cmd_o
);
  import sqvb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (sts_i.opcode)
            OP_BEGIN: cmd_o.clear = 1'b1;
            OP_END:   state_d = S_ONE;
            OP_DRAW:  state_d = sts_i.batch_full ? S_ONE : S_TRIG;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.textured ? S_SCAN_RD : S_VERT;
      end
      S_SCAN_RD: begin
        state_d = sts_i.scan_end ? S_MISS : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.hit) begin
          cmd_o.hit = 1'b1;
          state_d   = S_VERT;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_MISS: begin
        cmd_o.miss = 1'b1;
        state_d    = S_VERT;
      end
      S_VERT: begin
        if (sts_i.out_free) begin
          cmd_o.load_vert = 1'b1;
          if (sts_i.last_vert) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_one = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // a new request is only taken with no command in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (state_q == S_IDLE))
    else $error("request taken outside idle");
  // four vertices leave before the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_vert && sts_i.last_vert) |=> (state_q == S_IDLE))
    else $error("vertex burst did not end in idle");
  // a single result only comes from the end/full path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_one |-> (state_q == S_ONE))
    else $error("single result loaded from wrong state");
endmodule

### design/sqvb_dp.sv
// Datapath: trig tables, corner products, texture slot table, output register.
`timescale 1ns / 1ps
module sqvb_dp #(
  parameter int MAX_QUADS        = 16384,
  parameter int TEXTURE_SLOTS    = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqvb_pkg::quad_req_t req_i,
  input  sqvb_pkg::dp_cmd_t   cmd_i,
  output sqvb_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sqvb_pkg::vert_req_t out_o
);
  import sqvb_pkg::*;

  localparam int KW = $clog2(SINE_TABLE_DEPTH);
  localparam int SW = $clog2(TEXTURE_SLOTS);
  localparam int UW = $clog2(TEXTURE_SLOTS + 1);
  localparam int QW = $clog2(MAX_QUADS + 1);
  localparam logic [UW-1:0] SLOTS_FULL = UW'(TEXTURE_SLOTS);
  localparam logic [QW-1:0] QUADS_MAX  = QW'(MAX_QUADS);

  // constant sine/cosine tables indexed by the angle bucket
  logic signed [17:0] sin_lut [SINE_TABLE_DEPTH];
  logic signed [17:0] cos_lut [SINE_TABLE_DEPTH];
  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_lut
    localparam logic [31:0] PH = 32'((64'(gi) << 32) / SINE_TABLE_DEPTH);
    assign sin_lut[gi] = sine_of_phase(PH);
    assign cos_lut[gi] = sine_of_phase(PH + 32'h4000_0000);
  end

  quad_req_t          req_q;
  logic [KW-1:0]      k_q;
  logic signed [17:0] sin_q, cos_q;
  logic signed [49:0] pa_q, pb_q, pc_q, pd_q;
  logic [UW-1:0]      slots_used_q;
  logic [QW-1:0]      quad_count_q;
  logic [UW-1:0]      scan_idx_q;
  logic [4:0]         slot_q;
  logic [1:0]         st_q;
  logic [1:0]         vcnt_q;
  logic               out_valid_q;
  vert_req_t          out_q;

  logic [31:0]   k_prod;
  logic [15:0]   ram_rdata;
  logic          ram_we;
  logic          out_free;
  logic [16:0]   index_count;
  logic          cu, cv;
  logic signed [51:0] ax, bx, cy, dy_t, dx_sum, dy_sum, dx, dy;
  vert_req_t     vert_d;

  assign k_prod = 32'(req_i.angle_turn) * 32'(SINE_TABLE_DEPTH);

  assign ram_we = cmd_i.miss && (slots_used_q < SLOTS_FULL);

  sqvb_ram #(
    .WIDTH (16),
    .DEPTH (TEXTURE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slots_used_q[SW-1:0]),
    .wdata_i (req_q.texture_id),
    .raddr_i (scan_idx_q[SW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
      k_q   <= k_prod[16 +: KW];
    end
    if (cmd_i.trig) begin
      sin_q <= sin_lut[k_q];
      cos_q <= cos_lut[k_q];
    end
    if (cmd_i.mul) begin
      pa_q <= cos_q * req_q.size_x;
      pb_q <= sin_q * req_q.size_y;
      pc_q <= sin_q * req_q.size_x;
      pd_q <= cos_q * req_q.size_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_used_q <= UW'(1);
      quad_count_q <= '0;
      scan_idx_q   <= UW'(1);
      slot_q       <= '0;
      st_q         <= ST_OK;
      vcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear && req_i.opcode == OP_BEGIN) begin
        slots_used_q <= UW'(1);
        quad_count_q <= '0;
      end
      if (cmd_i.mul) begin
        quad_count_q <= quad_count_q + QW'(1);
        scan_idx_q   <= UW'(1);
        slot_q       <= '0;
        st_q         <= ST_OK;
        vcnt_q       <= '0;
      end
      if (cmd_i.scan_next) begin
        scan_idx_q <= scan_idx_q + UW'(1);
      end
      if (cmd_i.hit) begin
        slot_q <= 5'(scan_idx_q);
      end
      if (cmd_i.miss) begin
        if (slots_used_q < SLOTS_FULL) begin
          slot_q       <= 5'(slots_used_q);
          slots_used_q <= slots_used_q + UW'(1);
        end else begin
          st_q <= ST_TEX_FULL;
        end
      end
      if (cmd_i.load_vert) begin
        vcnt_q <= vcnt_q + 2'd1;
      end
      if (cmd_i.load_vert || cmd_i.load_one) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign index_count = 17'({quad_count_q, 2'b00}) + 17'({quad_count_q, 1'b0});

  // corner order (0,0) (1,0) (1,1) (0,1)
  assign cu = (vcnt_q == 2'd1) || (vcnt_q == 2'd2);
  assign cv = vcnt_q[1];

  always_comb begin
    ax     = cu ? 52'(pa_q) : -52'(pa_q);
    bx     = cv ? 52'(pb_q) : -52'(pb_q);
    cy     = cu ? 52'(pc_q) : -52'(pc_q);
    dy_t   = cv ? 52'(pd_q) : -52'(pd_q);
    dx_sum = ax - bx + 52'sd65536;
    dy_sum = cy + dy_t + 52'sd65536;
    dx     = dx_sum >>> 17;
    dy     = dy_sum >>> 17;

    vert_d             = '0;
    vert_d.index_count = index_count;
    vert_d.last        = 1'b1;
    if (cmd_i.load_vert) begin
      vert_d.vert_x     = req_q.pos_x + dx[31:0];
      vert_d.vert_y     = req_q.pos_y + dy[31:0];
      vert_d.vert_z     = req_q.pos_z;
      vert_d.vert_rgba  = req_q.textured ? WHITE_RGBA : req_q.color_rgba;
      vert_d.tex_u      = cu;
      vert_d.tex_v      = cv;
      vert_d.tex_slot   = slot_q;
      vert_d.tiling_out = req_q.textured ? req_q.tiling : UNIT_TILING;
      vert_d.status     = st_q;
      vert_d.last       = (vcnt_q == 2'd3);
    end else if (req_q.opcode == OP_DRAW) begin
      vert_d.status = ST_BATCH_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vert || cmd_i.load_one) begin
      out_q <= vert_d;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign sts_o.opcode     = req_i.opcode;
  assign sts_o.batch_full = (quad_count_q >= QUADS_MAX);
  assign sts_o.textured   = req_q.textured;
  assign sts_o.scan_end   = (scan_idx_q >= slots_used_q);
  assign sts_o.hit        = (ram_rdata == req_q.texture_id);
  assign sts_o.out_free   = out_free;
  assign sts_o.last_vert  = (vcnt_q == 2'd3);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_vert || cmd_i.load_one) |-> out_free)
    else $error("result overwritten before taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slots_used_q >= UW'(1)) && (slots_used_q <= SLOTS_FULL))
    else $error("slot count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.miss && slots_used_q < SLOTS_FULL)
      |=> (slots_used_q == $past(slots_used_q) + UW'(1)))
    else $error("miss did not append a slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    quad_count_q <= QUADS_MAX)
    else $error("quad count past batch limit");
endmodule

### design/sprite_quad_vertex_batcher.sv
// Top level: quad command in, four vertices out, with texture slot batching.
`timescale 1ns / 1ps
// Begin and undefined opcodes: taken with no result.
// End, or draw on a full batch: one result, then ready again for the next request.
// Draw: trig table read, then products, then a read and a compare state per slot-table
//   entry compared (textured only, sequential RAM scan) plus a miss state on a miss,
//   then one vertex per cycle while the output register is free.
// Reset clears the state machine, the output valid, slots in use to 1 and quads to 0.
module sprite_quad_vertex_batcher #(
  parameter int MAX_QUADS        = 16384,
  parameter int TEXTURE_SLOTS    = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sqvb_cmd_if.sink          cmd_i,
  sqvb_vert_if.source       vert_o
);
  import sqvb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller sequences one request at a time
  sqvb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds batch state and the output register
  sqvb_dp #(
    .MAX_QUADS        (MAX_QUADS),
    .TEXTURE_SLOTS    (TEXTURE_SLOTS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (cmd_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (vert_o.valid),
    .out_ready_i (vert_o.ready),
    .out_o       (vert_o.data)
  );
endmodule
